// File: hdl/rfm_pkg.sv
// Shared widths, codes, state types and control structs of the reciprocal frequency meter.
package rfm_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CLK_W      = 27;
  localparam int unsigned FREQ_W     = 48;
  localparam int unsigned PROD_W     = CLK_W + CNT_W;
  localparam int unsigned NUM_W      = PROD_W + FRAC_BITS;
  localparam int unsigned STEP_W     = $clog2(NUM_W + 1);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [63:0] FREQ_MAX64 = (64'd1 << FREQ_W) - 64'd1;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd2;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RST    = 27'd80000000;
  localparam logic [TS_W-1:0]  WINDOW_LOW_RST  = 32'd1230769;
  localparam logic [TS_W-1:0]  WINDOW_HIGH_RST = 32'd1777777;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_FILT,
    ST_OUT
  } rfm_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_RUN,
    DV_DONE
  } div_phase_e;

  typedef struct packed {
    logic            capture;
    logic            clear;
    logic [TS_W-1:0] ts;
  } acc_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0] period_sum;
    logic [CNT_W-1:0] period_count;
    logic [SUM_W-1:0] window_sum;
    logic [CNT_W-1:0] window_count;
  } acc_state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [FREQ_W-1:0] quot;
    logic              valid;
  } div_rsp_t;

endpackage

// File: hdl/rfm_if.sv
// Handshake interfaces for the item, result and configuration channels.
interface rfm_item_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [rfm_pkg::TS_W-1:0]  cap_timestamp;

  modport source (output valid, output op, output cap_timestamp, input ready);
  modport sink   (input valid, input op, input cap_timestamp, output ready);
endinterface

interface rfm_result_if;
  logic                        valid;
  logic                        ready;
  logic [rfm_pkg::FREQ_W-1:0]  simple_freq;
  logic                        simple_valid;
  logic [rfm_pkg::FREQ_W-1:0]  filtered_freq;
  logic                        filtered_valid;
  logic [rfm_pkg::CNT_W-1:0]   simple_count;
  logic [rfm_pkg::CNT_W-1:0]   filtered_count;

  modport source (output valid, output simple_freq, output simple_valid,
                  output filtered_freq, output filtered_valid,
                  output simple_count, output filtered_count, input ready);
  modport sink   (input valid, input simple_freq, input simple_valid,
                  input filtered_freq, input filtered_valid,
                  input simple_count, input filtered_count, output ready);
endinterface

interface rfm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rfm_pkg::CFG_IDX_W-1:0]   index;
  logic [rfm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/reciprocal_frequency_meter_core.sv
// Top level of the reciprocal frequency meter: sequencer, configuration and result register.
//
//  Channel   Dir  Handshake     Payload
//  item_i    in   valid/ready   op, cap_timestamp
//  result_o  out  valid/ready   simple/filtered freq and valid, simple/filtered count
//  cfg_i     in   valid/ready   index (0 clock_hz, 1 window_low, 2 window_high), data
//
//  A capture item is accepted while idle and a new item may follow at once.
//  A read item holds the input through the accept cycle, two passes of the shared
//  divider, each a multiply step, NUM_W shift-subtract steps and a done step, then the
//  output state. A pass over an empty accumulator is only its done step.
//  Items are refused while a read is in progress and while its result waits for
//  the result register to empty. Captures are taken while a result waits.
//  Reset clears the accumulators and loads the register defaults; cfg_i is always ready.
module reciprocal_frequency_meter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  rfm_item_if.sink      item_i,
  rfm_result_if.source  result_o,
  rfm_cfg_if.sink       cfg_i
);

  rfm_pkg::rfm_state_e state_q, state_d;

  logic [rfm_pkg::CLK_W-1:0] clock_hz_q;
  logic [rfm_pkg::TS_W-1:0]  window_low_q;
  logic [rfm_pkg::TS_W-1:0]  window_high_q;

  rfm_pkg::acc_ctl_t   acc_ctl;
  rfm_pkg::acc_state_t acc;
  rfm_pkg::div_req_t   div_req;
  rfm_pkg::div_rsp_t   div_rsp;

  logic                       item_fire;
  logic                       out_load;
  logic                       res_valid_q;
  logic [rfm_pkg::FREQ_W-1:0] sfreq_q;
  logic                       svalid_q;
  logic [rfm_pkg::FREQ_W-1:0] ffreq_q;
  logic                       fvalid_q;
  logic [rfm_pkg::FREQ_W-1:0] res_sfreq_q;
  logic                       res_svalid_q;
  logic [rfm_pkg::FREQ_W-1:0] res_ffreq_q;
  logic                       res_fvalid_q;
  logic [rfm_pkg::CNT_W-1:0]  res_scount_q;
  logic [rfm_pkg::CNT_W-1:0]  res_fcount_q;

  assign item_fire = item_i.valid && item_i.ready;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q    <= rfm_pkg::CLOCK_HZ_RST;
      window_low_q  <= rfm_pkg::WINDOW_LOW_RST;
      window_high_q <= rfm_pkg::WINDOW_HIGH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rfm_pkg::CFG_CLOCK_HZ:    clock_hz_q    <= cfg_i.data[rfm_pkg::CLK_W-1:0];
        rfm_pkg::CFG_WINDOW_LOW:  window_low_q  <= cfg_i.data;
        rfm_pkg::CFG_WINDOW_HIGH: window_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rfm_pkg::ST_IDLE: begin
        if (item_fire && (item_i.op == rfm_pkg::OP_READ)) begin
          state_d = rfm_pkg::ST_SIMPLE;
        end
      end
      rfm_pkg::ST_SIMPLE: begin
        if (div_rsp.done) begin
          state_d = rfm_pkg::ST_FILT;
        end
      end
      rfm_pkg::ST_FILT: begin
        if (div_rsp.done) begin
          state_d = rfm_pkg::ST_OUT;
        end
      end
      rfm_pkg::ST_OUT: begin
        if (!res_valid_q || result_o.ready) begin
          state_d = rfm_pkg::ST_IDLE;
        end
      end
      default: state_d = rfm_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    item_i.ready   = 1'b0;
    acc_ctl.capture = 1'b0;
    acc_ctl.clear   = 1'b0;
    acc_ctl.ts      = item_i.cap_timestamp;
    div_req.start   = 1'b0;
    div_req.sum     = acc.period_sum;
    div_req.count   = acc.period_count;
    out_load        = 1'b0;
    case (state_q)
      rfm_pkg::ST_IDLE: begin
        // ready is high throughout idle, so valid alone marks a transaction
        item_i.ready    = 1'b1;
        acc_ctl.capture = item_i.valid && (item_i.op == rfm_pkg::OP_CAPTURE);
        div_req.start   = item_i.valid && (item_i.op == rfm_pkg::OP_READ);
      end
      rfm_pkg::ST_SIMPLE: begin
        // chain the filtered pass straight after the plain one
        div_req.start = div_rsp.done;
        div_req.sum   = acc.window_sum;
        div_req.count = acc.window_count;
      end
      rfm_pkg::ST_FILT: ;
      rfm_pkg::ST_OUT: begin
        out_load      = !res_valid_q || result_o.ready;
        acc_ctl.clear = out_load;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfm_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_rsp.done && (state_q == rfm_pkg::ST_SIMPLE)) begin
      sfreq_q  <= div_rsp.quot;
      svalid_q <= div_rsp.valid;
    end
    if (div_rsp.done && (state_q == rfm_pkg::ST_FILT)) begin
      ffreq_q  <= div_rsp.quot;
      fvalid_q <= div_rsp.valid;
    end
    if (out_load) begin
      res_sfreq_q  <= sfreq_q;
      res_svalid_q <= svalid_q;
      res_ffreq_q  <= ffreq_q;
      res_fvalid_q <= fvalid_q;
      res_scount_q <= acc.period_count;
      res_fcount_q <= acc.window_count;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.simple_freq    = res_sfreq_q;
  assign result_o.simple_valid   = res_svalid_q;
  assign result_o.filtered_freq  = res_ffreq_q;
  assign result_o.filtered_valid = res_fvalid_q;
  assign result_o.simple_count   = res_scount_q;
  assign result_o.filtered_count = res_fcount_q;

  rfm_acc u_acc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (acc_ctl),
    .window_low_i  (window_low_q),
    .window_high_i (window_high_q),
    .acc_o         (acc)
  );

  rfm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clock_hz_i (clock_hz_q),
    .req_i      (div_req),
    .rsp_o      (div_rsp)
  );

  a_res_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == rfm_pkg::ST_OUT))
    else $error("result raised outside the output state");

  a_clear_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (acc.period_count == '0) && (acc.window_count == '0)
                 && (acc.period_sum == '0) && (acc.window_sum == '0))
    else $error("accumulators not cleared after a read");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_svalid_q) |-> (res_sfreq_q == '0))
    else $error("empty plain accumulator gave a nonzero frequency");

  a_capture_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_ctl.capture |=> acc.period_count == $past(acc.period_count) + rfm_pkg::CNT_W'(1))
    else $error("capture did not advance the period count");

endmodule

// File: hdl/rfm_acc.sv
// Period extraction, window filter and the four wrapping accumulators.
module rfm_acc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rfm_pkg::acc_ctl_t          ctl_i,
  input  logic [rfm_pkg::TS_W-1:0]   window_low_i,
  input  logic [rfm_pkg::TS_W-1:0]   window_high_i,
  output rfm_pkg::acc_state_t        acc_o
);

  logic [rfm_pkg::TS_W-1:0] last_ts_q, last_ts_d;
  rfm_pkg::acc_state_t      acc_q, acc_d;
  logic [rfm_pkg::TS_W-1:0] period;
  logic                     in_window;

  assign period    = ctl_i.ts - last_ts_q;
  assign in_window = (period > window_low_i) && (period < window_high_i);

  always_comb begin
    last_ts_d = last_ts_q;
    acc_d     = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.capture) begin
      last_ts_d          = ctl_i.ts;
      acc_d.period_sum   = acc_q.period_sum + period;
      acc_d.period_count = acc_q.period_count + rfm_pkg::CNT_W'(1);
      if (in_window) begin
        acc_d.window_sum   = acc_q.window_sum + period;
        acc_d.window_count = acc_q.window_count + rfm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ts_q <= '0;
      acc_q     <= '0;
    end else begin
      last_ts_q <= last_ts_d;
      acc_q     <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: hdl/rfm_div.sv
// Shared multiply then restoring shift-subtract divider: clock_hz*count*2^FRAC / sum.
module rfm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rfm_pkg::CLK_W-1:0]   clock_hz_i,
  input  rfm_pkg::div_req_t           req_i,
  output rfm_pkg::div_rsp_t           rsp_o
);

  rfm_pkg::div_phase_e phase_q, phase_d;

  logic [rfm_pkg::SUM_W-1:0]  div_q;
  logic [rfm_pkg::CNT_W-1:0]  cnt_q;
  logic [rfm_pkg::CLK_W-1:0]  clk_q;
  logic                       valid_q;
  logic [rfm_pkg::NUM_W-1:0]  num_q;
  logic [rfm_pkg::SUM_W-1:0]  rem_q;
  logic [rfm_pkg::STEP_W-1:0] step_q;

  logic                        take;
  logic                        empty;
  logic [rfm_pkg::PROD_W-1:0]  prod;
  logic [rfm_pkg::SUM_W:0]     rem_s;
  logic [rfm_pkg::SUM_W:0]     rem_diff;
  logic                        qbit;
  logic [rfm_pkg::SUM_W-1:0]   rem_n;
  logic [63:0]                 quot_x;
  logic                        sat;

  assign empty = (req_i.count == '0) || (req_i.sum == '0);
  assign take  = req_i.start && ((phase_q == rfm_pkg::DV_IDLE) || (phase_q == rfm_pkg::DV_DONE));

  assign prod     = rfm_pkg::PROD_W'(clk_q) * rfm_pkg::PROD_W'(cnt_q);
  assign rem_s    = {rem_q, num_q[rfm_pkg::NUM_W-1]};
  assign rem_diff = rem_s - {1'b0, div_q};
  assign qbit     = (rem_s >= {1'b0, div_q});
  assign rem_n    = qbit ? rem_diff[rfm_pkg::SUM_W-1:0] : rem_s[rfm_pkg::SUM_W-1:0];

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      rfm_pkg::DV_IDLE, rfm_pkg::DV_DONE: begin
        if (take) begin
          phase_d = empty ? rfm_pkg::DV_DONE : rfm_pkg::DV_MUL;
        end else begin
          phase_d = rfm_pkg::DV_IDLE;
        end
      end
      rfm_pkg::DV_MUL: phase_d = rfm_pkg::DV_RUN;
      rfm_pkg::DV_RUN: begin
        if (step_q == rfm_pkg::STEP_W'(1)) begin
          phase_d = rfm_pkg::DV_DONE;
        end
      end
      default: phase_d = rfm_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rfm_pkg::DV_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      div_q   <= req_i.sum;
      cnt_q   <= req_i.count;
      clk_q   <= clock_hz_i;
      valid_q <= !empty;
      num_q   <= '0;
    end else if (phase_q == rfm_pkg::DV_MUL) begin
      num_q  <= rfm_pkg::NUM_W'(prod) << rfm_pkg::FRAC_BITS;
      rem_q  <= '0;
      step_q <= rfm_pkg::STEP_W'(rfm_pkg::NUM_W);
    end else if (phase_q == rfm_pkg::DV_RUN) begin
      // shift the next numerator bit in, quotient bits fill from the bottom
      rem_q  <= rem_n;
      num_q  <= {num_q[rfm_pkg::NUM_W-2:0], qbit};
      step_q <= step_q - rfm_pkg::STEP_W'(1);
    end
  end

  // clamp to the result width
  assign quot_x = 64'(num_q);
  assign sat    = quot_x > rfm_pkg::FREQ_MAX64;

  always_comb begin
    rsp_o.done  = (phase_q == rfm_pkg::DV_DONE);
    rsp_o.busy  = (phase_q == rfm_pkg::DV_MUL) || (phase_q == rfm_pkg::DV_RUN);
    rsp_o.valid = valid_q;
    rsp_o.quot  = sat ? rfm_pkg::FREQ_MAX64[rfm_pkg::FREQ_W-1:0]
                      : quot_x[rfm_pkg::FREQ_W-1:0];
  end

endmodule

// File: test/reciprocal_frequency_meter_checker.sv
// Reading predictor and comparator for the reciprocal frequency meter core.
`timescale 1ns / 1ps

module reciprocal_frequency_meter_checker
  import rfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rfm_item_if         item_mon,
  rfm_result_if       result_mon,
  rfm_cfg_if          cfg_mon,
  output int unsigned results_seen_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic [FREQ_W-1:0] simple_freq;
    logic              simple_valid;
    logic [FREQ_W-1:0] filtered_freq;
    logic              filtered_valid;
    logic [CNT_W-1:0]  simple_count;
    logic [CNT_W-1:0]  filtered_count;
  } reading_t;

  reading_t readings_q[$];

  logic [CLK_W-1:0] clk_hz;
  logic [TS_W-1:0]  win_lo;
  logic [TS_W-1:0]  win_hi;
  logic [TS_W-1:0]  last_ts;
  logic [SUM_W-1:0] all_sum;
  logic [CNT_W-1:0] all_cnt;
  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] win_cnt;
  int unsigned      errors = 0;

  // {valid, frequency}: clock_hz * count / sum in fixed point, saturated to 48 bits
  function automatic logic [FREQ_W:0] frequency_of(input logic [SUM_W-1:0] sum,
                                                   input logic [CNT_W-1:0] cnt);
    logic [63:0] num;
    logic [63:0] quot;
    if (cnt == '0 || sum == '0) return '0;
    num  = (64'(clk_hz) * 64'(cnt)) << FRAC_BITS;
    quot = num / 64'(sum);
    if (quot > FREQ_MAX64) quot = FREQ_MAX64;
    return {1'b1, quot[FREQ_W-1:0]};
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    reading_t        got;
    reading_t        want;
    logic [TS_W-1:0] period;
    logic [FREQ_W:0] sf;
    logic [FREQ_W:0] ff;
    if (!rst_ni) begin
      clk_hz  = CLOCK_HZ_RST;
      win_lo  = WINDOW_LOW_RST;
      win_hi  = WINDOW_HIGH_RST;
      last_ts = '0;
      all_sum = '0;
      all_cnt = '0;
      win_sum = '0;
      win_cnt = '0;
      readings_q.delete();
      results_seen_o <= 0;
      fail_count_o   <= errors;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_CLOCK_HZ:    clk_hz = cfg_mon.data[CLK_W-1:0];
          CFG_WINDOW_LOW:  win_lo = cfg_mon.data;
          CFG_WINDOW_HIGH: win_hi = cfg_mon.data;
          default: ;
        endcase
      end

      // compare before taking this edge's item: a result never stems from it
      if (result_mon.valid && result_mon.ready) begin
        got = '{simple_freq:    result_mon.simple_freq,
                simple_valid:   result_mon.simple_valid,
                filtered_freq:  result_mon.filtered_freq,
                filtered_valid: result_mon.filtered_valid,
                simple_count:   result_mon.simple_count,
                filtered_count: result_mon.filtered_count};
        if (readings_q.size() == 0) begin
          $display("%0t: result transaction with no reading pending, expected none, got %h",
                   $time, got);
          errors++;
        end else begin
          want = readings_q.pop_front();
          check_field("simple_freq", want.simple_freq, got.simple_freq);
          check_field("simple_valid", want.simple_valid, got.simple_valid);
          check_field("filtered_freq", want.filtered_freq, got.filtered_freq);
          check_field("filtered_valid", want.filtered_valid, got.filtered_valid);
          check_field("simple_count", want.simple_count, got.simple_count);
          check_field("filtered_count", want.filtered_count, got.filtered_count);
        end
        results_seen_o <= results_seen_o + 1;
      end

      if (item_mon.valid && item_mon.ready) begin
        if (item_mon.op == OP_CAPTURE) begin
          period  = item_mon.cap_timestamp - last_ts;
          last_ts = item_mon.cap_timestamp;
          all_sum = all_sum + period;
          all_cnt = all_cnt + 1'b1;
          if (period > win_lo && period < win_hi) begin
            win_sum = win_sum + period;
            win_cnt = win_cnt + 1'b1;
          end
        end else begin
          sf = frequency_of(all_sum, all_cnt);
          ff = frequency_of(win_sum, win_cnt);
          readings_q.push_back('{simple_freq:    sf[FREQ_W-1:0],
                                 simple_valid:   sf[FREQ_W],
                                 filtered_freq:  ff[FREQ_W-1:0],
                                 filtered_valid: ff[FREQ_W],
                                 simple_count:   all_cnt,
                                 filtered_count: win_cnt});
          all_sum = '0;
          all_cnt = '0;
          win_sum = '0;
          win_cnt = '0;
        end
      end

      fail_count_o <= errors + readings_q.size();
    end
  end

endmodule

// File: test/reciprocal_frequency_meter_core_tb.sv
// Stimulus, handshake pacing and verdict for the reciprocal frequency meter core.
`timescale 1ns / 1ps

module reciprocal_frequency_meter_core_tb;
  import rfm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 16;

  typedef enum {PER_INSIDE, PER_EDGE, PER_ANY, PER_TINY} period_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rfm_item_if   item_ch ();
  rfm_result_if result_ch ();
  rfm_cfg_if    cfg_ch ();

  int unsigned results_seen;
  int unsigned fail_count;

  int unsigned items_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned settings   = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [TS_W-1:0] stim_ts = '0;
  logic [TS_W-1:0] cur_lo  = WINDOW_LOW_RST;
  logic [TS_W-1:0] cur_hi  = WINDOW_HIGH_RST;

  always #4 clk_i = ~clk_i;

  reciprocal_frequency_meter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  reciprocal_frequency_meter_checker reading_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_mon       (item_ch),
    .result_mon     (result_ch),
    .cfg_mon        (cfg_ch),
    .results_seen_o (results_seen),
    .fail_count_o   (fail_count)
  );

  // Result side: alternate ready stretches with random stalls
  initial begin
    int unsigned left;
    bit          level;
    left  = 0;
    level = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        level = !level;
        if (level) left = ($urandom_range(3) == 0) ? $urandom_range(60, 30) : $urandom_range(8, 1);
        else left = $urandom_range(20, 1);
      end
      result_ch.ready <= level;
      left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the item until accepted; open a new burst after a random gap when due
  task automatic send_item(input logic op, input logic [TS_W-1:0] ts);
    if (burst_left == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 40) : $urandom_range(16, 1);
    end
    item_ch.valid         <= 1'b1;
    item_ch.op            <= op;
    item_ch.cap_timestamp <= ts;
    do @(posedge clk_i); while (!item_ch.ready);
    if (burst_left > 0) burst_left--;
    items_sent++;
    if (op == OP_READ) reads_sent++;
    else stim_ts = ts;
  endtask

  task automatic send_period(input logic [TS_W-1:0] period);
    send_item(OP_CAPTURE, stim_ts + period);
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (results_seen != reads_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Write clock_hz and both window bounds, optionally followed by an unmapped index
  task automatic apply_setting(input logic [31:0] clk_data, input logic [TS_W-1:0] lo,
                               input logic [TS_W-1:0] hi, input bit spare);
    int unsigned i;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    cfg_ch.valid <= 1'b1;
    for (i = 0; i < (spare ? 4 : 3); i++) begin
      case (i)
        0:       begin idx = CFG_CLOCK_HZ;    data = clk_data; end
        1:       begin idx = CFG_WINDOW_LOW;  data = lo;       end
        2:       begin idx = CFG_WINDOW_HIGH; data = hi;       end
        default: begin idx = CFG_SPARE;       data = $urandom; end
      endcase
      cfg_ch.index <= idx;
      cfg_ch.data  <= data;
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    settings++;
  endtask

  function automatic logic [TS_W-1:0] pick_period(input period_kind_e kind);
    case (kind)
      PER_INSIDE: begin
        if (cur_lo < cur_hi && cur_hi - cur_lo > 1) return $urandom_range(cur_hi - 1, cur_lo + 1);
        return $urandom;
      end
      PER_EDGE: begin
        case ($urandom_range(5))
          0:       return cur_lo - 1;
          1:       return cur_lo;
          2:       return cur_lo + 1;
          3:       return cur_hi - 1;
          4:       return cur_hi;
          default: return cur_hi + 1;
        endcase
      end
      PER_TINY: return $urandom_range(3);
      default:  return $urandom;
    endcase
  endfunction

  // Mostly runs of plausible periods closed by a read; some stray reads and jumps
  task automatic random_phase(input int unsigned n_items);
    int unsigned  first;
    int unsigned  len;
    int unsigned  r;
    period_kind_e kind;
    first = items_sent;
    while (items_sent - first < n_items) begin
      r = $urandom_range(99);
      if (r < 10) send_item(OP_READ, $urandom);
      else if (r < 20) begin
        repeat ($urandom_range(4, 1)) send_item(OP_CAPTURE, $urandom);
      end else begin
        r = $urandom_range(9);
        kind = (r < 6) ? PER_INSIDE : (r == 6) ? PER_EDGE : (r == 7) ? PER_TINY : PER_ANY;
        len = $urandom_range(24, 1);
        repeat (len) begin
          if ($urandom_range(9) == 0) send_period(pick_period(PER_EDGE));
          else send_period(pick_period(kind));
        end
        send_item(OP_READ, $urandom);
      end
    end
  endtask

  initial begin
    logic [TS_W-1:0] lo;
    item_ch.valid         <= 1'b0;
    item_ch.op            <= OP_CAPTURE;
    item_ch.cap_timestamp <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_CLOCK_HZ;
    cfg_ch.data           <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty read, first edge from zero, strict window bounds
    send_item(OP_READ, 32'hFFFF_FFFF);
    send_item(OP_CAPTURE, 32'd1500000);
    send_period(cur_lo);
    send_period(cur_lo + 1);
    send_period(cur_hi);
    send_period(cur_hi - 1);
    send_item(OP_READ, 32'h0);
    // timer wrap between edges, then a sum that wraps to zero
    send_item(OP_CAPTURE, 32'hFFFF_FFFF);
    send_item(OP_CAPTURE, 32'h000F_0000);
    send_item(OP_READ, $urandom);
    send_period(32'h8000_0000);
    send_period(32'h8000_0000);
    send_item(OP_READ, $urandom);
    send_period(32'h0);
    send_period(32'hFFFF_FFFF);
    send_item(OP_READ, 32'h0);
    random_phase(100);

    // slowest clock, widest window
    apply_setting(32'd1, 32'h0, 32'hFFFF_FFFF, 1'b0);
    random_phase(100);

    // fastest clock written with all bits set; many zero periods saturate the frequency
    apply_setting(32'hFFFF_FFFF, 32'd1000, 32'd3000, 1'b1);
    send_period(32'd1);
    repeat (63) send_period(32'd0);
    send_item(OP_READ, $urandom);
    random_phase(100);

    // windows that admit nothing
    apply_setting($urandom_range(134217727, 1), 32'hFFFF_FFFF, 32'h0, 1'b0);
    random_phase(50);
    apply_setting($urandom_range(134217727, 1), 32'd5, 32'd6, 1'b1);
    random_phase(50);

    lo = $urandom;
    apply_setting(($urandom & 32'hF800_0000) | $urandom_range(134217727, 1), lo,
                  lo + $urandom_range(32'h00FF_FFFF), 1'b0);
    random_phase(100);

    // narrow window that admits only a period of one tick
    apply_setting($urandom_range(134217727, 1), 32'd0, 32'd2, 1'b0);
    random_phase(30);

    apply_setting(CLOCK_HZ_RST, WINDOW_LOW_RST, WINDOW_HIGH_RST, 1'b0);
    random_phase(30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items including %0d reads over %0d register settings,",
             items_sent, reads_sent, settings + 1);
    $display("with saturated frequencies, wrapped sums and empty windows among them.");
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
